// File: design/blur3_pkg.sv
package blur3_pkg;

  // Line memory: one entry per column, holding the two previous rows.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 16;
  localparam int CFG_W     = 16;

  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int LINE_W    = 2 * PIX_W;

  // Sum of up to nine channel values, then 2*sum + count.
  localparam int SUM_W     = 12;
  localparam int NUM_W     = SUM_W + 1;

  // Rounded mean by reciprocal: floor(num * RECIP / 2^RECIP_SHIFT).
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_e;

  typedef logic [PIX_W-1:0] pixel_t;

  // Which neighbour rows and columns of an output lie inside the frame.
  typedef struct packed {
    logic       last;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } nbr_info_t;

  // ceil(2^18 / (2*cnt)) for every neighbour count that can occur.
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd6:    r = 18'd21846;
      4'd9:    r = 18'd14564;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/box_blur_3x3_rgb_unit.sv
// 3x3 box blur over an RGB raster stream. Pixels enter in raster order with
// func_i low; after the last pixel of a frame, feed width+1 more items (func_i
// high, or any item, since pixel data is dropped once the frame is complete) to
// flush the remaining outputs. Output k leaves after input k+width+1 is taken,
// each channel the mean of the in-frame neighbours rounded half up, and the
// final output of the frame carries last_of_frame_o. The block takes one item
// per clock when the output side keeps up; an item passes four register stages
// (line memory read, window, sums, reciprocal multiply) before the result it
// releases is offered. The rate is set by the single line memory, read and
// written once per item for the item's column, with a forwarding register
// covering back-to-back access to one column. A drain item sent while pixels
// are still expected is taken and dropped. A write to either register restarts
// the frame; write only while no results are outstanding.
module box_blur_3x3_rgb_unit
  import blur3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [CHAN_W-1:0]   red_in_i,
  input  logic [CHAN_W-1:0]   green_in_i,
  input  logic [CHAN_W-1:0]   blue_in_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CHAN_W-1:0]   red_out_o,
  output logic [CHAN_W-1:0]   green_out_o,
  output logic [CHAN_W-1:0]   blue_out_o,
  output logic                last_of_frame_o,

  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  // Configuration, held as effective (clamped) values.
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  // Frame bookkeeping.
  logic [COL_W-1:0]    in_col_q;    // column of the next stream item
  logic [HEIGHT_W-1:0] row_q;       // row of the next pixel; equals height while draining
  logic [WIDTH_W-1:0]  lead_q;      // items seen before the first output, up to width+1
  logic [HEIGHT_W-1:0] out_row_q;
  logic [COL_W-1:0]    out_col_q;

  // Read stage: line memory data returns.
  logic                rd_v_q;
  logic                rd_emit_q;
  logic [COL_W-1:0]    rd_addr_q;
  pixel_t              rd_pix_q;
  nbr_info_t           rd_info_q;
  logic [LINE_W-1:0]   rdata_q;
  logic                fwd_v_q;
  logic [LINE_W-1:0]   fwd_q;

  // Window stage: three columns of three rows, column 2 newest.
  pixel_t              win_q [3][3];
  logic                win_v_q;
  nbr_info_t           win_info_q;

  // Sum stage.
  logic                sum_v_q;
  logic [NUM_W-1:0]    num_q [3];
  logic [RECIP_W-1:0]  recip_q;
  logic                sum_last_q;

  // Output register.
  logic                out_v_q;
  logic [CHAN_W-1:0]   chan_q [3];
  logic                out_last_q;

  logic [LINE_W-1:0]   line_mem [MAX_WIDTH];

  logic                filling;
  logic                ignore;
  logic                acc;
  logic                take;
  logic                rd_adv;
  logic                sum_load;
  logic                out_load;
  logic                in_col_last;
  logic                lead_full;
  logic                out_col_last;
  logic                out_row_last;
  logic                frame_last;
  nbr_info_t           cur_info;
  pixel_t              pix_in;
  logic [LINE_W-1:0]   rd_word;
  pixel_t              col_top;
  pixel_t              col_mid;
  logic [LINE_W-1:0]   wdata;
  logic [SUM_W-1:0]    sum_c [3];
  logic [1:0]          rows_n;
  logic [1:0]          cols_n;
  logic [3:0]          cnt;
  logic [PROD_W-1:0]   prod [3];

  // Handshake and stage advance: each stage moves when the next one is free
  // or moving at the same edge.
  assign out_load   = sum_v_q & (~out_v_q | ~out_stall_i);
  assign sum_load   = win_v_q & (~sum_v_q | out_load);
  assign rd_adv     = rd_v_q & (~win_v_q | sum_load);
  assign in_stall_o = rd_v_q & ~rd_adv;
  assign acc        = in_valid_i & ~in_stall_o;

  assign filling = row_q < height_q;
  assign ignore  = filling & func_i;
  assign take    = acc & ~ignore;
  assign pix_in  = filling ? {red_in_i, green_in_i, blue_in_i} : '0;

  assign in_col_last  = (WIDTH_W'(in_col_q) + WIDTH_W'(1)) == width_q;
  assign lead_full    = lead_q == (width_q + WIDTH_W'(1));
  assign out_col_last = (WIDTH_W'(out_col_q) + WIDTH_W'(1)) == width_q;
  assign out_row_last = ({1'b0, out_row_q} + (HEIGHT_W + 1)'(1)) == {1'b0, height_q};
  assign frame_last   = out_row_last & out_col_last;

  // Neighbour index 0 is above / left, 2 is below / right.
  assign cur_info.last   = frame_last;
  assign cur_info.row_ok = {~out_row_last, 1'b1, out_row_q != '0};
  assign cur_info.col_ok = {~out_col_last, 1'b1, out_col_q != '0};

  // Memory entry holds {row two up, row one up} for its column.
  assign rd_word = fwd_v_q ? fwd_q : rdata_q;
  assign col_top = rd_word[LINE_W-1 -: PIX_W];
  assign col_mid = rd_word[PIX_W-1:0];
  assign wdata   = {col_mid, rd_pix_q};

  // Configuration and frame counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      in_col_q  <= '0;
      row_q     <= '0;
      lead_q    <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH: begin
          if (cfg_data_i[WIDTH_W-1:0] == '0) begin
            width_q <= WIDTH_W'(1);
          end else if (cfg_data_i[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) begin
            width_q <= WIDTH_W'(MAX_WIDTH);
          end else begin
            width_q <= cfg_data_i[WIDTH_W-1:0];
          end
        end
        CFG_IMAGE_HEIGHT: begin
          height_q <= (cfg_data_i == '0) ? HEIGHT_W'(1) : cfg_data_i;
        end
      endcase
      // Abort the frame in progress.
      in_col_q  <= '0;
      row_q     <= '0;
      lead_q    <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (take) begin
      in_col_q <= in_col_last ? '0 : in_col_q + COL_W'(1);
      if (filling && in_col_last) begin
        row_q <= row_q + HEIGHT_W'(1);
      end
      if (!lead_full) begin
        lead_q <= lead_q + WIDTH_W'(1);
      end else if (frame_last) begin
        // Final output goes out with this item: start a new frame.
        in_col_q  <= '0;
        row_q     <= '0;
        lead_q    <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else if (out_col_last) begin
        out_col_q <= '0;
        out_row_q <= out_row_q + HEIGHT_W'(1);
      end else begin
        out_col_q <= out_col_q + COL_W'(1);
      end
    end
  end

  // Line memory: read at accept, write back when the item leaves the read
  // stage.
  always_ff @(posedge clk_i) begin
    if (rd_adv) begin
      line_mem[rd_addr_q] <= wdata;
    end
    if (take) begin
      rdata_q <= line_mem[in_col_q];
    end
  end

  // Forward the write of the item ahead when it hits the same column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (take) begin
      fwd_v_q <= rd_adv && (rd_addr_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fwd_q     <= wdata;
      rd_addr_q <= in_col_q;
      rd_pix_q  <= pix_in;
      rd_emit_q <= lead_full;
      rd_info_q <= cur_info;
    end
  end

  // Shift the window by one column per item.
  always_ff @(posedge clk_i) begin
    if (rd_adv) begin
      win_q[0]    <= win_q[1];
      win_q[1]    <= win_q[2];
      win_q[2][0] <= col_top;
      win_q[2][1] <= col_mid;
      win_q[2][2] <= rd_pix_q;
      win_info_q  <= rd_info_q;
    end
  end

  // Masked sums over the window.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (win_info_q.row_ok[i] && win_info_q.col_ok[j]) begin
            sum_c[c] = sum_c[c] + SUM_W'(win_q[j][i][PIX_W-1-CHAN_W*c -: CHAN_W]);
          end
        end
      end
    end
    rows_n = 2'd1 + 2'(win_info_q.row_ok[0]) + 2'(win_info_q.row_ok[2]);
    cols_n = 2'd1 + 2'(win_info_q.col_ok[0]) + 2'(win_info_q.col_ok[2]);
    cnt    = 4'(rows_n) * 4'(cols_n);
  end

  always_ff @(posedge clk_i) begin
    if (sum_load) begin
      for (int c = 0; c < 3; c++) begin
        num_q[c] <= {sum_c[c], 1'b0} + NUM_W'(cnt);
      end
      recip_q    <= recip(cnt);
      sum_last_q <= win_info_q.last;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(num_q[c]) * PROD_W'(recip_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        chan_q[c] <= prod[c][RECIP_SHIFT +: CHAN_W];
      end
      out_last_q <= sum_last_q;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      win_v_q <= 1'b0;
      sum_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take) begin
        rd_v_q <= 1'b1;
      end else if (rd_adv) begin
        rd_v_q <= 1'b0;
      end

      // Items that release no output still shift the window, then drop.
      if (rd_adv) begin
        win_v_q <= rd_emit_q;
      end else if (sum_load) begin
        win_v_q <= 1'b0;
      end

      if (sum_load) begin
        sum_v_q <= 1'b1;
      end else if (out_load) begin
        sum_v_q <= 1'b0;
      end

      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign red_out_o       = chan_q[0];
  assign green_out_o     = chan_q[1];
  assign blue_out_o      = chan_q[2];
  assign last_of_frame_o = out_last_q;

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blur3_pkg::*;

  // Run limits, all in clock cycles or items.
  localparam int WATCHDOG   = 5000;  // cycles with no handshake of any kind
  localparam int LONG_HOLD  = 400;   // one long output stall, to back up the pipe
  localparam int DRAIN_GAP  = 8;     // settle time after the last result
  localparam int END_GAP    = 20;
  localparam int RAND_ITEMS = 300;
  localparam int SAT_ITEMS  = 1040;  // saturated-width frame, cut 16 pixels into row 1
  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } blur_px_t;

  typedef enum logic [1:0] {
    STEP_IGNORED,
    STEP_HELD,
    STEP_EMITTED
  } step_e;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  // One row of the directed plan: either a register write or an item, with
  // an optional hand-written expectation for the result that item releases.
  typedef struct packed {
    row_kind_e        kind;
    cfg_index_e       idx;
    logic [CFG_W-1:0] data;
    logic             func;
    pixel_t           px;
    logic             typed;
    blur_px_t         want;
  } plan_row_t;

  // DUT-facing signals, all known from time zero.
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              func        = 1'b0;
  logic [CHAN_W-1:0] red_in      = '0;
  logic [CHAN_W-1:0] green_in    = '0;
  logic [CHAN_W-1:0] blue_in     = '0;
  logic              out_stall   = 1'b0;
  logic              cfg_we      = 1'b0;
  logic              cfg_index   = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0]  cfg_data    = '0;

  logic              in_stall;
  logic              out_valid;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              last_of_frame;

  // Blur predictor state: raw register copies, pixel history ring, positions.
  int      width_reg  = WIDTH_RESET;
  int      height_reg = HEIGHT_RESET;
  pixel_t  hist_mem [HIST_DEPTH];
  int      hist_wr    = 0;
  int      px_col     = 0;
  int      px_row     = 0;
  int      outs_done  = 0;
  int      out_row    = 0;
  int      out_col    = 0;
  int      item_pos   = 0;

  blur_px_t  blurred_q [$];   // expected output pixels, oldest first
  plan_row_t plan [$];

  int unsigned fails      = 0;
  int          idle_count = 0;

  // Sender bookkeeping shared with the receiver's long-hold trigger.
  bit offering   = 1'b0;
  int frame_left = 0;
  int tx_left    = 0;
  bit tx_calm    = 1'b0;

  always #5 clk = ~clk;

  box_blur_3x3_rgb_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func),
    .red_in_i        (red_in),
    .green_in_i      (green_in),
    .blue_in_i       (blue_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .red_out_o       (red_out),
    .green_out_o     (green_out),
    .blue_out_o      (blue_out),
    .last_of_frame_o (last_of_frame),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Effective frame size: zero counts as one, width saturates at the line size.
  function automatic int cols_now();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int rows_now();
    return (height_reg < 1) ? 1 : height_reg;
  endfunction

  function automatic void rewind_frame();
    px_col    = 0;
    px_row    = 0;
    outs_done = 0;
    out_row   = 0;
    out_col   = 0;
    item_pos  = 0;
    hist_wr   = 0;
  endfunction

  // Advance the blur predictor by one accepted item. The history ring holds
  // 2*W+3 pixels, enough to reach every in-frame neighbor of the pending
  // output pixel, which trails the newest item by W+1 stream positions.
  function automatic step_e blur_step(input logic drain, input pixel_t px,
                                      output blur_px_t res);
    int w, h, depth, cur, pos, idx, back, rr, cc, cnt;
    int sum_r, sum_g, sum_b;
    bit filling;
    pixel_t nb;
    w       = cols_now();
    h       = rows_now();
    depth   = 2 * w + 3;
    res     = '0;
    filling = (px_row < h);
    // A drain while pixels are still due is dropped outright.
    if (filling && drain) return STEP_IGNORED;
    if (hist_wr >= depth) hist_wr = 0;
    cur           = hist_wr;
    // Once the frame is complete, any item is a drain and its data is lost.
    hist_mem[cur] = filling ? px : '0;
    hist_wr       = (cur + 1 >= depth) ? 0 : cur + 1;
    if (filling) begin
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        px_row++;
      end
    end
    pos = item_pos;
    item_pos++;
    if (pos < outs_done + w + 1) return STEP_HELD;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt   = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = out_row + dr;
        cc = out_col + dc;
        // Leave out neighbors beyond the frame border.
        if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
          back = w + 1 - (dr * w + dc);
          idx  = cur + depth - back;
          if (idx >= depth) idx -= depth;
          nb    = hist_mem[idx];
          sum_r += nb[23:16];
          sum_g += nb[15:8];
          sum_b += nb[7:0];
          cnt++;
        end
      end
    end
    // Round half up.
    res.red   = CHAN_W'((2 * sum_r + cnt) / (2 * cnt));
    res.green = CHAN_W'((2 * sum_g + cnt) / (2 * cnt));
    res.blue  = CHAN_W'((2 * sum_b + cnt) / (2 * cnt));
    res.last  = (outs_done + 1 >= w * h);
    if (res.last) begin
      rewind_frame();
    end else begin
      outs_done++;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return STEP_EMITTED;
  endfunction

  function automatic pixel_t rand_px();
    // Mostly random, sometimes saturated channels to hit the sum extremes.
    if ($urandom_range(0, 7) == 0) begin
      return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
              ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
              ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
    end
    return PIX_W'($urandom);
  endfunction

  function automatic void plan_cfg(input cfg_index_e idx, input logic [CFG_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(input logic drain, input pixel_t px,
                                    input logic typed, input blur_px_t want);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_ITEM;
    row.func  = drain;
    row.px    = px;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // Lower valid only if it is up, so no edge sees two assignments to it.
  task automatic drop_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Always wait for a clock edge first, so a valid dropped just before is not
  // raised again in the same time step.
  task automatic wait_results();
    do @(posedge clk); while (blurred_q.size() != 0);
  endtask

  // Offer one item after a random gap, hold it until taken, then predict.
  task automatic push_item(input logic drain, input pixel_t px, input bit typed,
                           input blur_px_t want, output bit took);
    int       gap;
    blur_px_t got;
    step_e    st;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(10, 60);
    end
    tx_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    offering = 1'b1;
    func     <= drain;
    red_in   <= px[23:16];
    green_in <= px[15:8];
    blue_in  <= px[7:0];
    do @(posedge clk); while (in_stall);
    st = blur_step(drain, px, got);
    if (typed) blurred_q.push_back(want);
    else if (st == STEP_EMITTED) blurred_q.push_back(got);
    took = (st != STEP_IGNORED);
  endtask

  // Write a register once the block has gone quiet; the write restarts the frame.
  task automatic write_reg(input cfg_index_e idx, input logic [CFG_W-1:0] data);
    drop_valid();
    wait_results();
    // Drain items that release nothing may still be in flight.
    repeat (DRAIN_GAP) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = int'(data[WIDTH_W-1:0]);
    else height_reg = int'(data[HEIGHT_W-1:0]);
    rewind_frame();
  endtask

  // Receiver: stall randomly before each item, with calm stretches, and once a
  // long hold while the sender is mid-frame.
  initial begin : rx_side
    int n;
    int seen;
    int rx_left;
    bit rx_calm;
    bit held;
    seen    = 0;
    rx_left = 0;
    rx_calm = 1'b0;
    held    = 1'b0;
    forever begin
      if (!held && seen >= 60 && offering && frame_left >= 16) begin
        held = 1'b1;
        n    = LONG_HOLD;
      end else begin
        if (rx_left == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
          rx_left = $urandom_range(10, 60);
        end
        rx_left--;
        n = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
      seen++;
    end
  end

  // Compare every accepted output pixel with the oldest expectation.
  always @(posedge clk) begin
    blur_px_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (blurred_q.size() == 0) begin
        $error("output pixel with nothing expected: r=%0d g=%0d b=%0d last=%0b",
               red_out, green_out, blue_out, last_of_frame);
        fails++;
      end else begin
        exp_px = blurred_q.pop_front();
        if (red_out !== exp_px.red) begin
          $error("red_out: expected %0d, got %0d", exp_px.red, red_out);
          fails++;
        end
        if (green_out !== exp_px.green) begin
          $error("green_out: expected %0d, got %0d", exp_px.green, green_out);
          fails++;
        end
        if (blue_out !== exp_px.blue) begin
          $error("blue_out: expected %0d, got %0d", exp_px.blue, blue_out);
          fails++;
        end
        if (last_of_frame !== exp_px.last) begin
          $error("last_of_frame: expected %0b, got %0b", exp_px.last, last_of_frame);
          fails++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    bit     took;
    bit     must_cfg;
    bit     first;
    bit     paused_once;
    int     rand_items;
    int     w, h, n_px, n_all, cut, which;
    pixel_t flat;

    rand_items  = 0;
    first       = 1'b1;
    must_cfg    = 1'b1;
    paused_once = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // 1x1 frame: a drain while the pixel is still due is dropped, then the
    // lone pixel comes back unchanged and flagged after two drains.
    plan_cfg(CFG_IMAGE_WIDTH, 16'd1);
    plan_cfg(CFG_IMAGE_HEIGHT, 16'd1);
    plan_item(1'b1, 24'h123456, 1'b0, '0);
    plan_item(1'b0, 24'hFF00FF, 1'b0, '0);
    plan_item(1'b1, 24'h000000, 1'b0, '0);
    plan_item(1'b1, 24'h000000, 1'b1, '{8'hFF, 8'h00, 8'hFF, 1'b1});

    // Zero width and height act as one; a pixel sent during the drain is lost.
    plan_cfg(CFG_IMAGE_WIDTH, 16'd0);
    plan_cfg(CFG_IMAGE_HEIGHT, 16'd0);
    plan_item(1'b0, 24'h00FF00, 1'b0, '0);
    plan_item(1'b0, 24'hFFFFFF, 1'b0, '0);
    plan_item(1'b1, 24'h000000, 1'b1, '{8'h00, 8'hFF, 8'h00, 1'b1});

    // 3x3 frame: corners, edges and the center average 4, 6 and 9 pixels.
    plan_cfg(CFG_IMAGE_WIDTH, 16'd3);
    plan_cfg(CFG_IMAGE_HEIGHT, 16'd3);
    for (int i = 0; i < 9; i++) begin
      plan_item(1'b0, {8'(i * 31), 8'(255 - i * 31), (i % 2 != 0) ? 8'hFF : 8'h00},
                1'b0, '0);
    end
    for (int i = 0; i < 4; i++) plan_item(1'(i % 2 == 0), 24'hA5A5A5, 1'b0, '0);

    // Tallest frame, cut short: a flat field blurs to itself.
    plan_cfg(CFG_IMAGE_WIDTH, 16'd2);
    plan_cfg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 5; i++) begin
      plan_item(1'b0, 24'hFF0080, 1'(i >= 3), '{8'hFF, 8'h00, 8'h80, 1'b0});
    end

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].data);
      else push_item(plan[i].func, plan[i].px, plan[i].typed, plan[i].want, took);
    end

    // Oversized width saturates to the line size; stop 16 pixels into row 1.
    write_reg(CFG_IMAGE_WIDTH, 16'h07FF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    frame_left = SAT_ITEMS;
    for (int i = 0; i < SAT_ITEMS; i++) begin
      push_item(1'b0, rand_px(), 1'b0, '0, took);
      frame_left--;
    end

    // Random frames: mostly well-formed with random content, some noise
    // drains, some frames cut short and aborted by a register write.
    while (rand_items < RAND_ITEMS) begin
      if (must_cfg || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0:       w = 0;
          1, 2:    w = $urandom_range(7, 40);
          default: w = $urandom_range(1, 6);
        endcase
        if (w > 6)                           h = $urandom_range(1, 3);
        else if ($urandom_range(0, 19) == 0) h = 0;
        else if ($urandom_range(0, 9) == 0)  h = $urandom_range(6, 12);
        else                                  h = $urandom_range(1, 5);
        which = first ? 2 : $urandom_range(0, 3);
        first = 1'b0;
        // Upper data bits of a width write are don't-care; toggle them.
        if (which != 1) write_reg(CFG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
        if (which != 0) write_reg(CFG_IMAGE_HEIGHT, 16'(h));
      end
      n_px  = cols_now() * rows_now();
      n_all = n_px + cols_now() + 1;
      cut   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n_all - 1) : n_all;
      frame_left = cut;
      for (int i = 0; i < cut; i++) begin
        if (i < n_px) begin
          if ($urandom_range(0, 9) == 0) push_item(1'b1, rand_px(), 1'b0, '0, took);
          // Hold off the sender until every pending pixel is out.
          if ((!paused_once && rand_items > 100) || $urandom_range(0, 79) == 0) begin
            paused_once = 1'b1;
            drop_valid();
            wait_results();
          end
          push_item(1'b0, rand_px(), 1'b0, '0, took);
        end else begin
          flat = rand_px();
          push_item(1'($urandom_range(0, 3) != 0), flat, 1'b0, '0, took);
        end
        rand_items += took;
        frame_left--;
      end
      must_cfg = (cut != n_all);
      // A drain at the start of the next frame must be dropped.
      if (!must_cfg && $urandom_range(0, 4) == 0) push_item(1'b1, rand_px(), 1'b0, '0, took);
    end

    drop_valid();
    wait_results();
    repeat (END_GAP) @(posedge clk);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
